// ----- rtl/tgl_pkg.sv -----
// ----------------------------------------------------------------------------
// tgl_pkg: shared definitions for the text glyph layout block
// Register indexes, byte codes and the saturating cursor arithmetic.
// ----------------------------------------------------------------------------
package tgl_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FONT_READY   = 2'd2;

  localparam logic [7:0] GLYPH_WIDTH_RST  = 8'd16;
  localparam logic [7:0] GLYPH_HEIGHT_RST = 8'd16;

  // byte codes
  localparam logic [7:0] LEAD_LIMIT   = 8'h80;  // lead bytes lie above this
  localparam logic [7:0] SPACE        = 8'h20;
  localparam logic [7:0] ASCII_SPLIT  = 8'h5F;
  localparam logic [7:0] ASCII_END    = 8'h7F;
  localparam logic [7:0] FULL_ROW     = 8'hA3;
  localparam logic [7:0] LOW_OFS_A    = 8'h20;
  localparam logic [7:0] LOW_OFS_B    = 8'h21;
  localparam logic [7:0] NEWLINE      = 8'h0A;

  localparam logic [14:0] OFFSET_MAX  = 15'h7FFF;

  // clamp a 17-bit signed sum to the 16-bit signed range
  function automatic logic signed [15:0] sat17(input logic signed [16:0] s);
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return s[15:0];
  endfunction

  // signed coordinate plus a non-negative line offset
  function automatic logic signed [15:0] add_offset(input logic signed [15:0] a,
                                                    input logic [14:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + $signed({2'b00, b});
    return sat17(s);
  endfunction

  // signed coordinate plus a line height
  function automatic logic signed [15:0] add_height(input logic signed [15:0] a,
                                                    input logic [7:0] h);
    logic signed [16:0] s;
    s = {a[15], a} + $signed({9'd0, h});
    return sat17(s);
  endfunction

  // advance the line offset, holding at its maximum
  function automatic logic [14:0] advance(input logic [14:0] off,
                                          input logic [7:0] amt);
    logic [15:0] s;
    s = {1'b0, off} + {8'd0, amt};
    return s[15] ? OFFSET_MAX : s[14:0];
  endfunction

endpackage

// ----- rtl/text_glyph_layout.sv -----
// ----------------------------------------------------------------------------
// text_glyph_layout: glyph placement for double-byte-coded strings
// Takes one string byte per transfer and emits glyph position and code.
// ----------------------------------------------------------------------------
// One byte is taken per clock. Each accepted byte updates the layout cursor in
// the same cycle and, when it completes a glyph, loads the output register, so
// a glyph appears on the master side the cycle after its last byte. The output
// register decouples the two sides: s_tready stays high while the output is
// empty or being taken, so a full stream runs at one byte per cycle and stalls
// only while a finished glyph waits on m_tready. Bytes above 0x80 (not last)
// pair with the next byte; printable ASCII maps to row 0xA3. A byte with no
// glyph (lead byte, space, control, newline, or font not ready) gives no
// output transfer. Configuration writes are meant for idle periods only.
module text_glyph_layout (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  // text_byte[7:0], start_x[23:8], start_y[39:24], follow_x[40], follow_y[41],
  // wrap_width[56:42], zero fill above
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,   // last_byte
  input  logic        s_tuser,   // first_byte
  // glyph stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  // glyph_x[15:0], glyph_y[31:16], code_high[39:32], code_low[47:40]
  output logic [47:0] m_tdata
);
  import tgl_pkg::*;

  // configuration registers
  logic [7:0] glyph_width;
  logic [7:0] glyph_height;
  logic       font_ready;

  // layout state
  logic signed [15:0] origin_x, origin_x_next;
  logic signed [15:0] line_y, line_y_next;
  logic [14:0]        line_offset, line_offset_next;
  logic [14:0]        active_wrap, active_wrap_next;
  logic [7:0]         held_lead, held_lead_next;
  logic               lead_waiting, lead_waiting_next;
  logic               swallow_newline, swallow_newline_next;
  logic signed [15:0] end_x, end_x_next;
  logic signed [15:0] end_y, end_y_next;

  // output register
  logic signed [15:0] glyph_x, glyph_x_next;
  logic signed [15:0] glyph_y, glyph_y_next;
  logic [7:0]         code_high, code_high_next;
  logic [7:0]         code_low, code_low_next;

  // unpacked input fields
  logic [7:0]         text_byte;
  logic               first_byte;
  logic               last_byte;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic               follow_x;
  logic               follow_y;
  logic [14:0]        wrap_width;

  logic in_fire;
  logic out_load;
  logic glyph_done;

  assign text_byte  = s_tdata[7:0];
  assign start_x    = s_tdata[23:8];
  assign start_y    = s_tdata[39:24];
  assign follow_x   = s_tdata[40];
  assign follow_y   = s_tdata[41];
  assign wrap_width = s_tdata[56:42];
  assign first_byte = s_tuser;
  assign last_byte  = s_tlast;

  // accept while the output register is free or draining this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // Cursor update: written in the order the byte is handled, each step
  // working on the result of the one before.
  always_comb begin
    origin_x_next        = origin_x;
    line_y_next          = line_y;
    line_offset_next     = line_offset;
    active_wrap_next     = active_wrap;
    held_lead_next       = held_lead;
    lead_waiting_next    = lead_waiting;
    swallow_newline_next = swallow_newline;
    end_x_next           = end_x;
    end_y_next           = end_y;
    glyph_x_next         = glyph_x;
    glyph_y_next         = glyph_y;
    code_high_next       = code_high;
    code_low_next        = code_low;
    out_load             = 1'b0;
    glyph_done           = 1'b0;

    if (in_fire && font_ready) begin
      // first byte: load the origin, drop any held lead byte
      if (first_byte) begin
        origin_x_next        = follow_x ? end_x : start_x;
        line_y_next          = follow_y ? end_y : start_y;
        line_offset_next     = '0;
        active_wrap_next     = (wrap_width < {6'd0, glyph_width, 1'b0}) ? '0 : wrap_width;
        lead_waiting_next    = 1'b0;
        held_lead_next       = '0;
        swallow_newline_next = 1'b0;
      end

      if (swallow_newline_next && text_byte == NEWLINE) begin
        // newline right after a wrap: drop it
        swallow_newline_next = 1'b0;
      end else begin
        swallow_newline_next = 1'b0;
        if (lead_waiting_next) begin
          // second byte of a pair: emit the full-width glyph
          out_load          = 1'b1;
          glyph_x_next      = add_offset(origin_x_next, line_offset_next);
          glyph_y_next      = line_y_next;
          code_high_next    = held_lead_next;
          code_low_next     = text_byte;
          lead_waiting_next = 1'b0;
          line_offset_next  = advance(line_offset_next, glyph_width);
          glyph_done        = 1'b1;
        end else if (text_byte > LEAD_LIMIT && !last_byte) begin
          // hold the lead byte for its partner
          held_lead_next    = text_byte;
          lead_waiting_next = 1'b1;
        end else begin
          if (text_byte > SPACE && text_byte < ASCII_SPLIT) begin
            out_load       = 1'b1;
            glyph_x_next   = add_offset(origin_x_next, line_offset_next);
            glyph_y_next   = line_y_next;
            code_high_next = FULL_ROW;
            code_low_next  = LOW_OFS_A + text_byte;
          end else if (text_byte >= ASCII_SPLIT && text_byte < ASCII_END) begin
            out_load       = 1'b1;
            glyph_x_next   = add_offset(origin_x_next, line_offset_next);
            glyph_y_next   = line_y_next;
            code_high_next = FULL_ROW;
            code_low_next  = LOW_OFS_B + text_byte;
          end
          if (text_byte != NEWLINE) begin
            // half-width advance for ASCII, space and control bytes
            line_offset_next = advance(line_offset_next, {1'b0, glyph_width[7:1]});
          end else begin
            line_offset_next = '0;
            line_y_next      = add_height(line_y_next, glyph_height);
          end
          glyph_done = 1'b1;
        end

        // automatic wrap once the offset passes the wrap width
        if (glyph_done && active_wrap_next != '0 && line_offset_next > active_wrap_next) begin
          swallow_newline_next = !last_byte;
          line_offset_next     = '0;
          line_y_next          = add_height(line_y_next, glyph_height);
        end
      end

      // latch the end position for a following string
      if (last_byte) begin
        end_x_next = add_offset(origin_x_next, line_offset_next);
        end_y_next = line_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= GLYPH_WIDTH_RST;
      glyph_height <= GLYPH_HEIGHT_RST;
      font_ready   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data;
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data;
        REG_FONT_READY:   font_ready   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      line_y          <= '0;
      line_offset     <= '0;
      active_wrap     <= '0;
      held_lead       <= '0;
      lead_waiting    <= 1'b0;
      swallow_newline <= 1'b0;
      end_x           <= '0;
      end_y           <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      origin_x        <= origin_x_next;
      line_y          <= line_y_next;
      line_offset     <= line_offset_next;
      active_wrap     <= active_wrap_next;
      held_lead       <= held_lead_next;
      lead_waiting    <= lead_waiting_next;
      swallow_newline <= swallow_newline_next;
      end_x           <= end_x_next;
      end_y           <= end_y_next;
      // load on a new glyph, clear once the held glyph is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload needs no reset
  always_ff @(posedge clk) begin
    glyph_x   <= glyph_x_next;
    glyph_y   <= glyph_y_next;
    code_high <= code_high_next;
    code_low  <= code_low_next;
  end

  assign m_tdata = {code_low, code_high, glyph_y, glyph_x};

  // a glyph is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output glyph overwritten before transfer");

  // no glyph without a loaded font
  a_font_gate: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !font_ready) |=> !m_tvalid || $past(m_tvalid && !m_tready))
    else $error("glyph emitted while font not ready");

  // a string never ends with a lead byte held
  a_last_clears_lead: assert property (@(posedge clk) disable iff (rst)
    (in_fire && font_ready && last_byte) |=> !lead_waiting)
    else $error("lead byte held past last byte");

  // the swallow mark and a held lead byte exclude each other
  a_swallow_lead: assert property (@(posedge clk) disable iff (rst)
    !(swallow_newline && lead_waiting))
    else $error("swallow armed while lead byte held");

endmodule

// ----- tb/text_glyph_layout_check.sv -----
// ----------------------------------------------------------------------------
// text_glyph_layout_check: glyph stream checker
// Follows the register writes and the byte transfers, predicts each glyph
// with its own layout cursor and compares every glyph transfer in order.
// ----------------------------------------------------------------------------
module text_glyph_layout_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // text_byte[7:0], start_x[23:8], start_y[39:24], follow_x[40], follow_y[41],
  // wrap_width[56:42], zero fill above
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,   // last_byte
  input  logic        s_tuser,   // first_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  // glyph_x[15:0], glyph_y[31:16], code_high[39:32], code_low[47:40]
  input  logic [47:0] m_tdata,
  output int          errors,
  output int          outstanding,
  output int          glyphs_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import tgl_pkg::*;

  // members from the top bit down, so the struct overlays m_tdata
  typedef struct packed {
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } glyph_t;

  glyph_t pending_glyphs[$];

  logic [7:0]         gw = GLYPH_WIDTH_RST;
  logic [7:0]         gh = GLYPH_HEIGHT_RST;
  logic               ready = 1'b0;
  logic signed [15:0] org_x = '0;
  logic signed [15:0] cur_y = '0;
  logic signed [15:0] fin_x = '0;
  logic signed [15:0] fin_y = '0;
  logic [14:0]        offset = '0;
  logic [14:0]        wrap_lim = '0;
  logic [7:0]         lead = '0;
  bit                 lead_held = 1'b0;
  bit                 skip_nl = 1'b0;
  int                 n_err = 0;
  int                 n_checked = 0;

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic glyph_t place(input logic [7:0] hi, input logic [7:0] lo);
    glyph_t g;
    g.x  = clamp16(int'(org_x) + int'(offset));
    g.y  = cur_y;
    g.hi = hi;
    g.lo = lo;
    return g;
  endfunction

  task automatic step_offset(input logic [7:0] amt);
    int s;
    s = int'(offset) + int'(amt);
    offset = (s > 32767) ? 15'h7FFF : s[14:0];
  endtask

  task automatic new_line();
    offset = '0;
    cur_y = clamp16(int'(cur_y) + int'(gh));
  endtask

  // Advance the cursor for one byte and queue the glyph it completes, if any.
  task automatic lay_out_byte(input logic [63:0] d, input bit first, input bit last);
    logic [7:0] b;
    bit done;
    b = d[7:0];
    done = 1'b0;
    if (!ready) return;
    if (first) begin
      org_x = d[40] ? fin_x : d[23:8];
      cur_y = d[41] ? fin_y : d[39:24];
      offset = '0;
      wrap_lim = (int'(d[56:42]) < 2 * int'(gw)) ? 15'd0 : d[56:42];
      lead_held = 1'b0;
      lead = '0;
      skip_nl = 1'b0;
    end
    if (skip_nl && b == NEWLINE) begin
      skip_nl = 1'b0;
    end else begin
      skip_nl = 1'b0;
      if (lead_held) begin
        // second byte of a pair is the low code, whatever it is
        pending_glyphs.push_back(place(lead, b));
        lead_held = 1'b0;
        step_offset(gw);
        done = 1'b1;
      end else if (b > LEAD_LIMIT && !last) begin
        lead = b;
        lead_held = 1'b1;
      end else begin
        if (b > SPACE && b < ASCII_SPLIT) begin
          pending_glyphs.push_back(place(FULL_ROW, LOW_OFS_A + b));
        end else if (b >= ASCII_SPLIT && b < ASCII_END) begin
          pending_glyphs.push_back(place(FULL_ROW, LOW_OFS_B + b));
        end
        if (b != NEWLINE) begin
          step_offset(gw >> 1);
        end else begin
          new_line();
        end
        done = 1'b1;
      end
      if (done && wrap_lim != 0 && offset > wrap_lim) begin
        skip_nl = !last;
        new_line();
      end
    end
    if (last) begin
      fin_x = clamp16(int'(org_x) + int'(offset));
      fin_y = cur_y;
    end
  endtask

  always @(posedge clk) begin
    glyph_t got;
    glyph_t want;
    if (rst) begin
      gw = GLYPH_WIDTH_RST;
      gh = GLYPH_HEIGHT_RST;
      ready = 1'b0;
      org_x = '0;
      cur_y = '0;
      fin_x = '0;
      fin_y = '0;
      offset = '0;
      wrap_lim = '0;
      lead = '0;
      lead_held = 1'b0;
      skip_nl = 1'b0;
      pending_glyphs.delete();
    end else begin
      // a glyph leaves through the output register after its byte is taken, so compare before predicting
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        n_checked++;
        if (pending_glyphs.size() == 0) begin
          $error("glyph transfer with none predicted: x=%0d y=%0d code=%02h%02h",
                 got.x, got.y, got.hi, got.lo);
          n_err++;
        end else begin
          want = pending_glyphs.pop_front();
          if (got.x !== want.x) begin
            $error("glyph_x: expected %0d, actual %0d", want.x, got.x);
            n_err++;
          end
          if (got.y !== want.y) begin
            $error("glyph_y: expected %0d, actual %0d", want.y, got.y);
            n_err++;
          end
          if (got.hi !== want.hi) begin
            $error("code_high: expected %02h, actual %02h", want.hi, got.hi);
            n_err++;
          end
          if (got.lo !== want.lo) begin
            $error("code_low: expected %02h, actual %02h", want.lo, got.lo);
            n_err++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GLYPH_WIDTH:  gw = cfg_data;
          REG_GLYPH_HEIGHT: gh = cfg_data;
          REG_FONT_READY:   ready = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        lay_out_byte(s_tdata, s_tuser, s_tlast);
      end
    end
    errors <= n_err;
    outstanding <= pending_glyphs.size();
    glyphs_checked <= n_checked;
  end

endmodule

// ----- tb/text_glyph_layout_test.sv -----
// ----------------------------------------------------------------------------
// text_glyph_layout_test: testbench top for the text glyph layout block
// Drives register settings and byte strings with random gaps on both sides;
// the checker beside the block predicts and compares every glyph.
// ----------------------------------------------------------------------------
module text_glyph_layout_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tgl_pkg::*;

  localparam int        STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int        RANDOM_BYTES = 2000;
  localparam logic [1:0] REG_SPARE   = 2'd3;  // no register here; writes must be ignored

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  int errors;
  int outstanding;
  int glyphs_checked;

  // string origin used for the next first byte
  logic signed [15:0] org_x = '0;
  logic signed [15:0] org_y = '0;
  bit                 fol_x = 1'b0;
  bit                 fol_y = 1'b0;
  logic [14:0]        wrap = '0;
  logic [7:0]         cur_gw = GLYPH_WIDTH_RST;

  bit steady = 1'b0;     // no gaps and no stalls while set
  int n_bytes = 0;
  int n_settings = 0;
  int quiet = 0;
  int rdy_left = 0;

  text_glyph_layout uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  text_glyph_layout_check checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .errors        (errors),
    .outstanding   (outstanding),
    .glyphs_checked(glyphs_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: alternate runs of ready and stall of random length.
  always @(posedge clk) begin
    if (steady) begin
      m_tready <= 1'b1;
      rdy_left <= 0;
    end else if (rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 2) != 0);
      rdy_left <= gap_len();
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Present one byte and hold it until the transfer. Returns in the step of
  // the accepting edge, with s_tvalid still high.
  task automatic send(input logic [7:0] b, input bit first, input bit last,
                      input logic [15:0] sx, input logic [15:0] sy,
                      input bit fx, input bit fy, input logic [14:0] ww);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, ww, fy, fx, sy, sx, b};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_bytes++;
  endtask

  // Send a byte; only a first byte carries the origin, other bytes carry junk.
  task automatic put(input logic [7:0] b, input bit first, input bit last);
    logic [31:0] r1;
    logic [31:0] r2;
    if (first) begin
      send(b, 1'b1, last, org_x, org_y, fol_x, fol_y, wrap);
    end else begin
      r1 = $urandom;
      r2 = $urandom;
      send(b, 1'b0, last, r1[15:0], r1[31:16], r2[0], r2[1], r2[16:2]);
    end
  endtask

  // Drop valid, let every predicted glyph drain, then allow the block to settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers on back-to-back edges, plus the unused index.
  task automatic write_regs(input logic [7:0] w, input logic [7:0] h, input bit on);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GLYPH_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_GLYPH_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_index <= REG_FONT_READY;
    cfg_data  <= {7'd0, on};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_gw = w;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    if (r < 30) return 16'(16'h7FFF - $urandom_range(0, 600));
    return 16'($urandom);
  endfunction

  // Wrap width: off, full range, right at the enable threshold, or a few glyphs.
  function automatic logic [14:0] pick_wrap();
    int r;
    int base;
    int w;
    r = $urandom_range(0, 99);
    base = 2 * int'(cur_gw);
    if (r < 30) return '0;
    if (r < 40) return 15'($urandom);
    if (r < 55) return 15'(base - int'($urandom_range(0, 1)));
    w = base + $urandom_range(0, 8 * int'(cur_gw));
    return (w > 32767) ? 15'h7FFF : w[14:0];
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 60) return 8'($urandom_range(8'h81, 8'hFF));
    if (r < 75) return NEWLINE;
    if (r < 85) return (r < 80) ? SPACE : 8'($urandom_range(0, 8'h1F));
    return 8'($urandom);
  endfunction

  // One random string; a few lack a last mark, a few run on after it.
  task automatic random_string(output int sent);
    int len;
    bit cut;
    int extra;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    cut = ($urandom_range(0, 9) == 0);
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    org_x = pick_coord();
    org_y = pick_coord();
    fol_x = $urandom_range(0, 3) == 0;
    fol_y = $urandom_range(0, 3) == 0;
    wrap = pick_wrap();
    for (int i = 0; i < len; i++) begin
      put(pick_byte(), i == 0, (i == len - 1) && !cut);
    end
    for (int i = 0; i < extra; i++) begin
      put(pick_byte(), 1'b0, i == extra - 1);
    end
    sent = len + extra;
  endtask

  initial begin
    int n_random;
    int in_phase;
    int sent;
    int p;
    logic [7:0] w;
    logic [7:0] h;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // font not loaded out of reset: these bytes must leave no trace
    org_x = 16'sd5;
    org_y = 16'sd7;
    put("A", 1'b1, 1'b0);
    put("B", 1'b0, 1'b1);
    wait_idle();

    // directed strings at the default glyph size
    write_regs(GLYPH_WIDTH_RST, GLYPH_HEIGHT_RST, 1'b1);
    org_x = 16'sd100;
    org_y = 16'sd50;
    wrap  = '0;
    put("A", 1'b1, 1'b0);
    put(8'h21, 1'b0, 1'b0);     // first printable below the split
    put(8'h5E, 1'b0, 1'b0);
    put(8'h5F, 1'b0, 1'b0);     // first byte of the upper printable range
    put(8'h7E, 1'b0, 1'b0);
    put(SPACE, 1'b0, 1'b0);
    put(ASCII_END, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(LEAD_LIMIT, 1'b0, 1'b0); // 0x80 itself is no lead byte
    put(NEWLINE, 1'b0, 1'b0);
    put(8'h81, 1'b0, 1'b0);
    put(8'h40, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(NEWLINE, 1'b0, 1'b0);   // low half of a pair, not a line break
    put(8'hB0, 1'b0, 1'b1);     // lead value on the last byte stands alone
    put("C", 1'b0, 1'b0);       // runs on after the last mark
    put(8'hC1, 1'b0, 1'b0);     // held lead dropped by the next first mark
    fol_x = 1'b1;
    fol_y = 1'b1;
    put("D", 1'b1, 1'b1);
    // wrap at exactly two glyph widths near the top corner, then a swallowed newline
    org_x = 16'sh7FFF;
    org_y = 16'sh7FF8;
    fol_x = 1'b0;
    fol_y = 1'b0;
    wrap  = 15'd32;
    put("E", 1'b1, 1'b0);
    repeat (4) put("E", 1'b0, 1'b0);
    put(NEWLINE, 1'b0, 1'b0);
    put("F", 1'b0, 1'b1);

    // random phases, each under its own register setting
    n_random = 0;
    p = 0;
    while (n_random < RANDOM_BYTES) begin
      case (p % 6)
        0: begin w = 8'd16;  h = 8'd16;  end
        1: begin w = 8'd1;   h = 8'd1;   end
        2: begin w = 8'd255; h = 8'd255; end
        3: begin w = 8'd8;   h = 8'd12;  end
        default: begin
          w = 8'($urandom_range(1, 255));
          h = 8'($urandom_range(1, 255));
        end
      endcase
      wait_idle();
      steady = (p % 4 == 3);
      write_regs(w, h, 1'b1);
      if (p == 2) begin
        // long run of full-width glyphs: the line offset pins at its maximum
        org_x = 16'sd1000;
        org_y = 16'sd0;
        wrap  = '0;
        for (int i = 0; i < 135; i++) begin
          put(8'h81 + i[6:0], i == 0, 1'b0);
          put(8'($urandom), 1'b0, i == 134);
        end
        n_random += 270;
      end
      in_phase = 0;
      while (in_phase < 300 && n_random < RANDOM_BYTES) begin
        random_string(sent);
        in_phase += sent;
        n_random += sent;
      end
      p++;
    end

    // font unloaded again: bytes are dropped
    wait_idle();
    steady = 1'b0;
    write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b0);
    repeat (5) random_string(sent);

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes under %0d register settings; %0d glyphs compared.",
             n_bytes, n_settings, glyphs_checked);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
